// ===== hdl/heisenberg_dmi_spin_flip_energy_top_assert.svh =====
`ifndef HEISENBERG_DMI_SPIN_FLIP_ENERGY_TOP_ASSERT_SVH
`define HEISENBERG_DMI_SPIN_FLIP_ENERGY_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define HDSF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hdsf assertion failed");

// next-cycle implication, sampled on clk, off during rst
`define HDSF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hdsf assertion failed");

`endif

// ===== hdl/hdsf_pkg.sv =====
package hdsf_pkg;

  localparam int LATTICE_DIMS   = 3;
  localparam int NUM_AXES       = 3;
  localparam int NUM_NEIGHBOURS = 6;
  localparam int STAGES         = 8;
  localparam int CFG_INDEX_W    = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_FIELD_X      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FIELD_Y      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FIELD_Z      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_EXCHANGE_X   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_EXCHANGE_Y   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_EXCHANGE_Z   = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_DMI_STRENGTH = 3'd6;

  typedef logic signed [15:0] spin_t;
  typedef logic signed [16:0] diff_t;
  typedef logic signed [18:0] nsum_t;
  typedef logic signed [23:0] coef_t;
  typedef logic signed [34:0] dmi_t;
  typedef logic signed [63:0] energy_t;

  typedef struct packed {
    diff_t d_self;
    diff_t d_next;
    diff_t d_prev;
    nsum_t nsum;
    diff_t nd_next;
    diff_t nd_prev;
  } lane_in_t;

  typedef struct packed {
    energy_t energy;
    dmi_t    dmi;
  } lane_out_t;

endpackage

// ===== hdl/heisenberg_dmi_spin_flip_energy_top.sv =====
// Metropolis energy change for one Heisenberg spin site with field, exchange and
// DMI terms. One item (current spin, trial spin, six neighbours) is taken every
// clock cycle while item_stall is low; the result passes through the
// eight-stage pipeline (input register, three stages in each of the three
// per-axis lanes, four in the merge that adds the DMI product and rounds).
// A stalled result freezes the whole pipeline, so item_stall follows
// result_stall while a result is held. Energy is scaled by 2^30. The
// coefficient registers are written through the cfg port, which is always
// ready outside reset; write them only while no transaction is in flight.
`include "heisenberg_dmi_spin_flip_energy_top_assert.svh"

module heisenberg_dmi_spin_flip_energy_top (
  input  logic                                 clk,
  input  logic                                 rst,

  input  logic                                 item_valid,
  output logic                                 item_stall,
  input  hdsf_pkg::spin_t                      spin_now_x,
  input  hdsf_pkg::spin_t                      spin_now_y,
  input  hdsf_pkg::spin_t                      spin_now_z,
  input  hdsf_pkg::spin_t                      spin_try_x,
  input  hdsf_pkg::spin_t                      spin_try_y,
  input  hdsf_pkg::spin_t                      spin_try_z,
  input  logic [47:0]                          neighbour_minus_x,
  input  logic [47:0]                          neighbour_plus_x,
  input  logic [47:0]                          neighbour_minus_y,
  input  logic [47:0]                          neighbour_plus_y,
  input  logic [47:0]                          neighbour_minus_z,
  input  logic [47:0]                          neighbour_plus_z,

  output logic                                 result_valid,
  input  logic                                 result_stall,
  output hdsf_pkg::energy_t                    energy_change,

  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [hdsf_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  hdsf_pkg::coef_t                      cfg_data
);
  import hdsf_pkg::*;

  coef_t field_r    [NUM_AXES];
  coef_t exchange_r [NUM_AXES];
  coef_t dmi_r;

  logic              en;
  logic [STAGES-1:0] valid_pipe;

  spin_t       now_v [NUM_AXES];
  spin_t       try_v [NUM_AXES];
  logic [47:0] nb    [NUM_NEIGHBOURS];
  diff_t       d_now [NUM_AXES];
  nsum_t       nsum  [NUM_AXES];

  lane_out_t [NUM_AXES-1:0] lane_out;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        field_r[i]    <= '0;
        exchange_r[i] <= '0;
      end
      dmi_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FIELD_X:      field_r[0]    <= cfg_data;
        REG_FIELD_Y:      field_r[1]    <= cfg_data;
        REG_FIELD_Z:      field_r[2]    <= cfg_data;
        REG_EXCHANGE_X:   exchange_r[0] <= cfg_data;
        REG_EXCHANGE_Y:   exchange_r[1] <= cfg_data;
        REG_EXCHANGE_Z:   exchange_r[2] <= cfg_data;
        REG_DMI_STRENGTH: dmi_r         <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg_ready = !rst;

  // pipeline control
  assign en           = !valid_pipe[STAGES-1] || !result_stall;
  assign item_stall   = rst || !en;
  assign result_valid = valid_pipe[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_pipe <= '0;
    end else if (en) begin
      valid_pipe <= {valid_pipe[STAGES-2:0], item_valid};
    end
  end

  assign now_v[0] = spin_now_x;
  assign now_v[1] = spin_now_y;
  assign now_v[2] = spin_now_z;
  assign try_v[0] = spin_try_x;
  assign try_v[1] = spin_try_y;
  assign try_v[2] = spin_try_z;

  assign nb[0] = neighbour_minus_x;
  assign nb[1] = neighbour_plus_x;
  assign nb[2] = neighbour_minus_y;
  assign nb[3] = neighbour_plus_y;
  assign nb[4] = neighbour_minus_z;
  assign nb[5] = neighbour_plus_z;

  // spin difference and neighbour sums over the used neighbours
  always_comb begin
    for (int c = 0; c < NUM_AXES; c++) begin
      d_now[c] = 17'(now_v[c]) - 17'(try_v[c]);
      nsum[c]  = '0;
      for (int i = 0; i < 2 * LATTICE_DIMS; i++) begin
        nsum[c] = nsum[c] + 19'($signed(nb[i][16*c +: 16]));
      end
    end
  end

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
    localparam int NX = (a + 1) % NUM_AXES;
    localparam int PV = (a + 2) % NUM_AXES;

    lane_in_t lane_in_c;
    lane_in_t lane_in_r;

    // plus minus minus neighbour on this axis, zero when the axis is unused
    always_comb begin
      lane_in_c.d_self = d_now[a];
      lane_in_c.d_next = d_now[NX];
      lane_in_c.d_prev = d_now[PV];
      lane_in_c.nsum   = nsum[a];
      if (a < LATTICE_DIMS) begin
        lane_in_c.nd_next = 17'($signed(nb[2*a+1][16*NX +: 16]))
                          - 17'($signed(nb[2*a][16*NX +: 16]));
        lane_in_c.nd_prev = 17'($signed(nb[2*a+1][16*PV +: 16]))
                          - 17'($signed(nb[2*a][16*PV +: 16]));
      end else begin
        lane_in_c.nd_next = '0;
        lane_in_c.nd_prev = '0;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        lane_in_r <= lane_in_c;
      end
    end

    hdsf_lane u_lane (
      .clk      (clk),
      .en       (en),
      .field    (field_r[a]),
      .exchange (exchange_r[a]),
      .lane_in  (lane_in_r),
      .lane_out (lane_out[a])
    );
  end

  hdsf_merge u_merge (
    .clk           (clk),
    .en            (en),
    .dmi_strength  (dmi_r),
    .lanes         (lane_out),
    .energy_change (energy_change)
  );

  `HDSF_ASSERT_NEXT(a_accept_enters_pipe, item_valid && !item_stall, valid_pipe[0])
  `HDSF_ASSERT_NOW(a_held_result_stalls_input, result_valid && result_stall, item_stall)
  `HDSF_ASSERT_NEXT(a_held_result_freezes_pipe, result_valid && result_stall, $stable(valid_pipe))
  `HDSF_ASSERT_NEXT(a_bubble_reaches_output, en && !valid_pipe[STAGES-2], !result_valid)

endmodule

// ===== hdl/hdsf_lane.sv =====
module hdsf_lane (
  input  logic                 clk,
  input  logic                 en,
  input  hdsf_pkg::coef_t      field,
  input  hdsf_pkg::coef_t      exchange,
  input  hdsf_pkg::lane_in_t   lane_in,
  output hdsf_pkg::lane_out_t  lane_out
);
  import hdsf_pkg::*;

  logic signed [33:0] cross_np;
  logic signed [33:0] cross_pn;

  logic signed [40:0] hd_b;
  logic signed [35:0] dn_b;
  dmi_t               dmi_b;

  logic signed [42:0] plo_c;
  logic signed [41:0] phi_c;
  logic signed [40:0] hd_c;
  dmi_t               dmi_c;

  energy_t            energy_d;
  dmi_t               dmi_d;

  assign cross_np = $signed(lane_in.d_next) * $signed(lane_in.nd_prev);
  assign cross_pn = $signed(lane_in.d_prev) * $signed(lane_in.nd_next);

  // field, d times neighbour sum, dmi cross terms
  always_ff @(posedge clk) begin
    if (en) begin
      hd_b  <= $signed(field) * $signed(lane_in.d_self);
      dn_b  <= $signed(lane_in.d_self) * $signed(lane_in.nsum);
      dmi_b <= 35'(cross_np) - 35'(cross_pn);
    end
  end

  // exchange product split in two halves
  always_ff @(posedge clk) begin
    if (en) begin
      plo_c <= $signed(exchange) * $signed({1'b0, dn_b[17:0]});
      phi_c <= $signed(exchange) * $signed(dn_b[35:18]);
      hd_c  <= hd_b;
      dmi_c <= dmi_b;
    end
  end

  // lane energy at scale 2^44
  always_ff @(posedge clk) begin
    if (en) begin
      energy_d <= {{9{hd_c[40]}}, hd_c, 14'd0} + 64'(plo_c)
                + {{4{phi_c[41]}}, phi_c, 18'd0};
      dmi_d    <= dmi_c;
    end
  end

  assign lane_out.energy = energy_d;
  assign lane_out.dmi    = dmi_d;

endmodule

// ===== hdl/hdsf_merge.sv =====
module hdsf_merge (
  input  logic                                        clk,
  input  logic                                        en,
  input  hdsf_pkg::coef_t                             dmi_strength,
  input  hdsf_pkg::lane_out_t [hdsf_pkg::NUM_AXES-1:0] lanes,
  output hdsf_pkg::energy_t                           energy_change
);
  import hdsf_pkg::*;

  energy_t            part_sum;
  logic signed [36:0] dmi_sum;

  energy_t            part_e;
  logic signed [36:0] dsum_e;

  logic signed [43:0] klo_f;
  logic signed [41:0] khi_f;
  energy_t            part_f;

  energy_t            total_g;
  energy_t            result_h;

  always_comb begin
    part_sum = '0;
    dmi_sum  = '0;
    for (int i = 0; i < NUM_AXES; i++) begin
      part_sum = part_sum + lanes[i].energy;
      dmi_sum  = dmi_sum + 37'($signed(lanes[i].dmi));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      part_e <= part_sum;
      dsum_e <= dmi_sum;
    end
  end

  // dmi strength product split in two halves
  always_ff @(posedge clk) begin
    if (en) begin
      klo_f  <= $signed(dmi_strength) * $signed({1'b0, dsum_e[18:0]});
      khi_f  <= $signed(dmi_strength) * $signed(dsum_e[36:19]);
      part_f <= part_e;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      total_g <= part_f + 64'(klo_f) + {{3{khi_f[41]}}, khi_f, 19'd0};
    end
  end

  // round to scale 2^30, ties toward plus infinity
  always_ff @(posedge clk) begin
    if (en) begin
      result_h <= (total_g + 64'sd8192) >>> 14;
    end
  end

  assign energy_change = result_h;

endmodule
